@@ rtl/syt_pkg.sv @@
// Shared types and constants for the sorted year table.
// Holds the command and result structs, the cell control struct and the codes.
// No dependencies.
package syt_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_RANGE  = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NONE      = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] item_year;
    logic signed [15:0] year_upper;
    logic [15:0]        item_payload;
    logic [4:0]         read_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         found_index;
    logic signed [15:0] entry_year;
    logic [15:0]        entry_payload;
    logic [5:0]         entry_total;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic               shift;
    logic signed [15:0] key;
    logic [15:0]        payload;
    logic signed [15:0] upper;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

endpackage

@@ rtl/sorted_year_table.sv @@
// Sorted year table: a row of cells kept in ascending year order.
// Start is taken in S_IDLE or with the last result; results strobe in S_EMIT.
// Each command passes S_CMP, then S_EMIT; a range query stays in S_EMIT for
// each extra match, streamed from one priority pick over the flags.
// Reset: entry count cleared; cell contents stay undefined until written.
// The receiver cannot stall: each result is on the ports for one cycle.
module sorted_year_table
  import syt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    strobe,
  output result_t result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  cmd_t             cmd_q;
  logic [DEPTH-1:0] flags;
  logic [DEPTH-1:0] flags_next;
  logic [CNT_W-1:0] count;

  cell_ctl_t          ctl;
  logic signed [15:0] cell_year [DEPTH];
  logic [15:0]        cell_payload [DEPTH];
  logic [DEPTH-1:0]   valid_vec;
  logic [DEPTH-1:0]   after_vec;
  logic [DEPTH-1:0]   eq_vec;
  logic [DEPTH-1:0]   range_vec;
  logic [DEPTH-1:0]   read_vec;

  logic [IDX_W-1:0] pick_idx;
  logic             pick_any;
  logic [DEPTH-1:0] pick_rest;
  logic             full;
  logic             last;
  logic             accept;

  assign full = (count == CNT_W'(DEPTH));

  assign ctl.shift   = (state == S_CMP) && (cmd_q.action == ACT_INSERT) && !full;
  assign ctl.key     = cmd_q.item_year;
  assign ctl.payload = cmd_q.item_payload;
  assign ctl.upper   = cmd_q.year_upper;
  assign ctl.count   = count;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               l_after;
    logic signed [15:0] l_year;
    logic [15:0]        l_payload;
    if (i == 0) begin : g_head
      assign l_after   = 1'b0;
      assign l_year    = '0;
      assign l_payload = '0;
    end else begin : g_body
      assign l_after   = after_vec[i-1];
      assign l_year    = cell_year[i-1];
      assign l_payload = cell_payload[i-1];
    end
    syt_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .idx          (IDX_W'(i)),
      .left_after   (l_after),
      .left_year    (l_year),
      .left_payload (l_payload),
      .year         (cell_year[i]),
      .payload      (cell_payload[i]),
      .valid        (valid_vec[i]),
      .after        (after_vec[i]),
      .eq           (eq_vec[i]),
      .in_range     (range_vec[i])
    );
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      read_vec[i] = valid_vec[i] && ({1'b0, cmd_q.read_index} == (IDX_W + 1)'(i));
    end
  end

  syt_pick u_pick (
    .flags (flags),
    .idx   (pick_idx),
    .any   (pick_any),
    .rest  (pick_rest)
  );

  assign last   = (cmd_q.action != ACT_RANGE) || !pick_any || (pick_rest == '0);
  assign busy   = (state == S_CMP) || ((state == S_EMIT) && !last);
  assign accept = start && !busy;
  assign strobe = (state == S_EMIT);

  always_comb begin
    result.entry_total = 6'(count);
    result.last_of_run = last;
    result.status        = ST_OK;
    result.found_index   = 5'(pick_idx);
    result.entry_year    = cell_year[pick_idx];
    result.entry_payload = cell_payload[pick_idx];
    case (cmd_q.action)
      ACT_INSERT: begin
        result.entry_year    = cmd_q.item_year;
        result.entry_payload = cmd_q.item_payload;
        if (!pick_any) begin
          result.status        = ST_FULL;
          result.found_index   = '0;
          result.entry_year    = '0;
          result.entry_payload = '0;
        end
      end
      ACT_READ: begin
        if (!pick_any) begin
          result.status        = ST_BAD_INDEX;
          result.found_index   = cmd_q.read_index;
          result.entry_year    = '0;
          result.entry_payload = '0;
        end
      end
      default: begin
        if (!pick_any) begin
          result.status        = ST_NONE;
          result.found_index   = '0;
          result.entry_year    = '0;
          result.entry_payload = '0;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    flags_next = flags;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_EMIT;
        case (cmd_q.action)
          ACT_INSERT: flags_next = full ? '0 : after_vec;
          ACT_FIND:   flags_next = eq_vec;
          ACT_RANGE:  flags_next = range_vec;
          default:    flags_next = read_vec;
        endcase
      end
      S_EMIT: begin
        flags_next = pick_rest;
        if (last) state_next = start ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctl.shift) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    flags <= flags_next;
    if (accept) cmd_q <= cmd;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctl.shift |=> count == $past(count) + 1'b1)
    else $error("insert did not advance entry count");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_of_run |-> !busy)
    else $error("busy held after final transfer");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    strobe && cmd_q.action != ACT_RANGE |-> result.last_of_run)
    else $error("single-result command not marked last");
`endif

endmodule

@@ rtl/syt_cell.sv @@
// One table position: holds a year and a payload, compares the year to the command.
// Takes its neighbor's entry, or the new entry, on a shifting insert. Depends on syt_pkg.
module syt_cell
  import syt_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [IDX_W-1:0]   idx,
  input  logic               left_after,
  input  logic signed [15:0] left_year,
  input  logic [15:0]        left_payload,
  output logic signed [15:0] year,
  output logic [15:0]        payload,
  output logic               valid,
  output logic               after,
  output logic               eq,
  output logic               in_range
);

  assign valid    = {1'b0, idx} < ctl.count;
  assign after    = !valid || (year > ctl.key);
  assign eq       = valid && (year == ctl.key);
  assign in_range = valid && (year >= ctl.key) && (year <= ctl.upper);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      if (left_after) begin
        year    <= left_year;
        payload <= left_payload;
      end else if (after) begin
        year    <= ctl.key;
        payload <= ctl.payload;
      end
    end
  end

endmodule

@@ rtl/syt_pick.sv @@
// Priority pick over the flag vector: lowest set position and the flags left.
// Depends on syt_pkg.
module syt_pick
  import syt_pkg::*;
(
  input  logic [DEPTH-1:0] flags,
  output logic [IDX_W-1:0] idx,
  output logic             any,
  output logic [DEPTH-1:0] rest
);

  always_comb begin
    idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (flags[i]) idx = IDX_W'(i);
    end
  end

  assign any  = |flags;
  assign rest = flags & ~({{(DEPTH - 1){1'b0}}, 1'b1} << idx);

endmodule

@@ dv/syt_checker.sv @@
// Result checker for the sorted year table: keeps its own copy of the table,
// predicts every result of each accepted command and compares it field by field.
// Depends on syt_pkg for the command and result structs and the codes.
module syt_checker
  import syt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    strobe,
  input  result_t result,
  output int      mismatches,
  output int      outstanding,
  output int      results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESULT_CAP = 32;

  logic signed [15:0] years_held [DEPTH];
  logic [15:0]        handles_held [DEPTH];
  int                 held;
  result_t            awaited_results [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    held         = 0;
  end

  function automatic result_t make_result(logic [1:0] st, int idx, logic signed [15:0] yr,
                                          logic [15:0] handle, logic last);
    result_t r;
    r.status        = st;
    r.found_index   = 5'(idx);
    r.entry_year    = yr;
    r.entry_payload = handle;
    r.entry_total   = 6'(held);
    r.last_of_run   = last;
    return r;
  endfunction

  task automatic predict_results(cmd_t c);
    int      i;
    int      pos;
    int      n;
    bit      have_hit;
    result_t hit;
    case (c.action)
      ACT_INSERT: begin
        if (held >= DEPTH) begin
          awaited_results.push_back(make_result(ST_FULL, 0, '0, '0, 1'b1));
        end else begin
          pos = held;
          for (i = held - 1; i >= 0; i--) begin
            if (years_held[i] > c.item_year) pos = i;
          end
          for (i = held; i > pos; i--) begin
            years_held[i]   = years_held[i-1];
            handles_held[i] = handles_held[i-1];
          end
          years_held[pos]   = c.item_year;
          handles_held[pos] = c.item_payload;
          held++;
          awaited_results.push_back(make_result(ST_OK, pos, c.item_year, c.item_payload, 1'b1));
        end
      end
      ACT_FIND: begin
        pos = -1;
        for (i = held - 1; i >= 0; i--) begin
          if (years_held[i] == c.item_year) pos = i;
        end
        if (pos < 0) begin
          awaited_results.push_back(make_result(ST_NONE, 0, '0, '0, 1'b1));
        end else begin
          awaited_results.push_back(make_result(ST_OK, pos, years_held[pos],
                                                handles_held[pos], 1'b1));
        end
      end
      ACT_RANGE: begin
        n = 0;
        have_hit = 1'b0;
        for (i = 0; i < held && n < RESULT_CAP; i++) begin
          if (years_held[i] >= c.item_year && years_held[i] <= c.year_upper) begin
            if (have_hit) awaited_results.push_back(hit);
            hit = make_result(ST_OK, i, years_held[i], handles_held[i], 1'b0);
            have_hit = 1'b1;
            n++;
          end
        end
        if (!have_hit) begin
          awaited_results.push_back(make_result(ST_NONE, 0, '0, '0, 1'b1));
        end else begin
          hit.last_of_run = 1'b1;
          awaited_results.push_back(hit);
        end
      end
      default: begin
        if (int'(c.read_index) < held) begin
          awaited_results.push_back(make_result(ST_OK, c.read_index, years_held[c.read_index],
                                                handles_held[c.read_index], 1'b1));
        end else begin
          awaited_results.push_back(make_result(ST_BAD_INDEX, c.read_index, '0, '0, 1'b1));
        end
      end
    endcase
  endtask

  task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (strobe) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no command outstanding: status %0d index %0d year %0d",
                 result.status, result.found_index, result.entry_year);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, result.status);
          check_field("found_index", want.found_index, result.found_index);
          check_field("entry_year", want.entry_year, result.entry_year);
          check_field("entry_payload", want.entry_payload, result.entry_payload);
          check_field("entry_total", want.entry_total, result.entry_total);
          check_field("last_of_run", want.last_of_run, result.last_of_run);
        end
      end
      if (start && !busy) predict_results(cmd);
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ dv/tb_sorted_year_table.sv @@
// Top of the sorted year table testbench: clock, reset, directed and random commands.
// Instantiates sorted_year_table and syt_checker; needs syt_pkg for the structs and codes.
module tb_sorted_year_table;
  import syt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int CMD_W       = $bits(cmd_t);

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  int mismatches;
  int outstanding;
  int results_seen;
  int sender_idle_pct = 37;
  int cycles = 0;
  int sent [4] = '{0, 0, 0, 0};
  logic signed [15:0] years_used [$];

  sorted_year_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  syt_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .strobe       (strobe),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_year_table NOT OK");
      $finish;
    end
  end

  task automatic issue(cmd_t c);
    while (busy || (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent[c.action]++;
    if (c.action == ACT_INSERT) years_used.push_back(c.item_year);
  endtask

  function automatic cmd_t make_cmd(logic [1:0] act, logic signed [15:0] yr,
                                    logic signed [15:0] upper, logic [15:0] handle,
                                    logic [4:0] idx);
    cmd_t c;
    c.action       = act;
    c.item_year    = yr;
    c.year_upper   = upper;
    c.item_payload = handle;
    c.read_index   = idx;
    return c;
  endfunction

  function automatic logic signed [15:0] pick_year();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2, 3: begin
        if (years_used.size() != 0) return years_used[$urandom_range(years_used.size() - 1)];
      end
      default: ;
    endcase
    return 16'($urandom);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   roll;
    int   top;
    c = CMD_W'({$urandom, $urandom});
    roll = $urandom_range(99);
    if (roll < 35)      c.action = ACT_INSERT;
    else if (roll < 55) c.action = ACT_FIND;
    else if (roll < 80) c.action = ACT_RANGE;
    else                c.action = ACT_READ;
    c.item_year = pick_year();
    if (c.action == ACT_RANGE) begin
      case ($urandom_range(3))
        0: ;
        1: begin
          c.item_year  = 16'sh8000;
          c.year_upper = 16'sh7FFF;
        end
        default: begin
          top = int'(c.item_year) + $urandom_range(0, 3000);
          c.year_upper = (top > 32767) ? 16'sh7FFF : 16'(top);
        end
      endcase
    end
    return c;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    issue(make_cmd(ACT_FIND, 16'sd0, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_RANGE, 16'sh8000, 16'sh7FFF, 16'h0000, 5'd0));
    issue(make_cmd(ACT_READ, 16'sd0, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_READ, 16'sd0, 16'sd0, 16'h0000, 5'd31));
    issue(make_cmd(ACT_INSERT, 16'sh7FFF, 16'sd0, 16'hFFFF, 5'd0));
    issue(make_cmd(ACT_INSERT, 16'sh8000, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_INSERT, 16'sd0, 16'sd0, 16'h1234, 5'd0));
    issue(make_cmd(ACT_INSERT, 16'sd0, 16'sd0, 16'h5678, 5'd0));
    issue(make_cmd(ACT_INSERT, 16'sd0, 16'sd0, 16'h9ABC, 5'd0));
    issue(make_cmd(ACT_FIND, 16'sd0, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_FIND, 16'sh8000, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_FIND, 16'sh7FFF, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_FIND, 16'sd1, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_RANGE, 16'sh8000, 16'sh7FFF, 16'h0000, 5'd0));
    issue(make_cmd(ACT_RANGE, 16'sd0, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_RANGE, 16'sd5, -16'sd5, 16'h0000, 5'd0));
    issue(make_cmd(ACT_RANGE, 16'sd1, 16'sd100, 16'h0000, 5'd0));
    issue(make_cmd(ACT_READ, 16'sd0, 16'sd0, 16'h0000, 5'd0));
    issue(make_cmd(ACT_READ, 16'sd0, 16'sd0, 16'h0000, 5'd4));
    issue(make_cmd(ACT_READ, 16'sd0, 16'sd0, 16'h0000, 5'd5));
    issue(make_cmd(ACT_READ, 16'sd0, 16'sd0, 16'h0000, 5'd31));

    repeat (60) issue(rand_cmd());
    sender_idle_pct = 57;
    repeat (50) issue(rand_cmd());
    sender_idle_pct = 0;
    repeat (50) issue(rand_cmd());
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Commands: %0d inserts, %0d finds, %0d range queries, %0d reads; %0d results.",
             sent[ACT_INSERT], sent[ACT_FIND], sent[ACT_RANGE], sent[ACT_READ], results_seen);
    $display("Table filled past capacity; sender idled at 37, 57 and 0 percent.");
    if (mismatches == 0) begin
      $display("tb_sorted_year_table OK");
    end else begin
      $display("tb_sorted_year_table NOT OK");
    end
    $finish;
  end

endmodule
